>>> rtl/core/battery_heater_thermostat_macros.svh
// Assertion macros for the battery heater thermostat; they expect clk and rst_n in scope.
`ifndef BATTERY_HEATER_THERMOSTAT_MACROS_SVH
`define BATTERY_HEATER_THERMOSTAT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BHT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bht_pkg.sv
// Shared types, codes and constants of the battery heater thermostat.
package bht_pkg;

  localparam int HEATER_PRESENT_DEF  = 1;
  localparam int SURFACE_SENSORS_DEF = 3;
  localparam int SENSOR_INPUTS       = 3;

  localparam int TEMP_W    = 8;
  localparam int SOC_W     = 14;
  localparam int CMD_W     = 3;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 14;

  localparam logic signed [TEMP_W-1:0] SURF_FLOOR = -8'sd99;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_AUTO        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FORCE_ON    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FORCE_OFF   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REINIT      = 3'd4;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_OFF      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FORCED   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BATT     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WALL     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ERROR    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DISABLED = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELL_ON_WALL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_OFF_WALL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_ON_BATT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_OFF_BATT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOC_MIN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SURF_ON       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SURF_OFF      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SURF_CRIT     = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [TEMP_W-1:0] min_cell_temp;
    logic signed [TEMP_W-1:0] surface_temp_a;
    logic signed [TEMP_W-1:0] surface_temp_b;
    logic signed [TEMP_W-1:0] surface_temp_c;
    logic                     wall_power;
    logic [SOC_W-1:0]         charge_level;
  } bht_in_t;

  typedef struct packed {
    logic                     heater_on;
    logic [MODE_W-1:0]        heater_mode;
    logic                     overheat_trip;
    logic signed [TEMP_W-1:0] surface_max;
  } bht_out_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] cell_on_temp_wall;
    logic signed [TEMP_W-1:0] cell_off_temp_wall;
    logic signed [TEMP_W-1:0] cell_on_temp_battery;
    logic signed [TEMP_W-1:0] cell_off_temp_battery;
    logic [SOC_W-1:0]         soc_min_for_heat;
    logic signed [TEMP_W-1:0] surface_on_temp;
    logic signed [TEMP_W-1:0] surface_off_temp;
    logic signed [TEMP_W-1:0] surface_critical_temp;
  } bht_cfg_t;

endpackage

>>> rtl/core/battery_heater_thermostat.sv
// Top level of the battery heater thermostat: input and result registers around the control.
//
// Usage: each input word on in_word is one sensor sample with an optional manual
// command; every accepted word yields exactly one result word on out_word, in order.
// A word is taken when in_valid is high and in_stall low; a result is taken when
// out_valid is high and out_stall low. Configuration writes on cfg_valid/cfg_ready
// (always ready) select a register by cfg_index and load cfg_data; the surface and
// cell thresholds use the low eight bits. Write configuration only while idle.
// An accepted word passes the input register, then the mode update and result
// register, before out_valid rises for its result. Throughput is one word per cycle
// while out_stall is low; the mode, drive and override state are updated as each
// word leaves the input register. While out_stall is high a valid result holds,
// the input register fills and then in_stall rises; no word is dropped. Reset
// (rst_n low, synchronous) empties both registers, loads the register defaults and
// puts the mode to off (disabled when no heater is fitted) with the drive and the
// manual override cleared.
`include "battery_heater_thermostat_macros.svh"

module battery_heater_thermostat #(
  parameter int HEATER_PRESENT  = bht_pkg::HEATER_PRESENT_DEF,
  parameter int SURFACE_SENSORS = bht_pkg::SURFACE_SENSORS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bht_pkg::bht_in_t              in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bht_pkg::bht_out_t             out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bht_pkg::CFG_DAT_W-1:0] cfg_data
);

  bht_pkg::bht_cfg_t cfg;
  bht_pkg::bht_in_t  s1_word_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  bht_pkg::bht_out_t out_word_r;
  bht_pkg::bht_out_t result;
  logic              advance;
  logic signed [bht_pkg::TEMP_W-1:0] smax;

  bht_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bht_surface_max #(
    .SURFACE_SENSORS (SURFACE_SENSORS)
  ) u_smax (
    .temp_a      (s1_word_r.surface_temp_a),
    .temp_b      (s1_word_r.surface_temp_b),
    .temp_c      (s1_word_r.surface_temp_c),
    .surface_max (smax)
  );

  bht_mode_ctrl #(
    .HEATER_PRESENT (HEATER_PRESENT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .word_in  (s1_word_r),
    .smax     (smax),
    .cfg      (cfg),
    .word_out (result)
  );

  // The word in the input register moves on when the result register is free or emptying.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = advance ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_word_r <= in_word;
    end
    if (advance) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `BHT_ASSERT_IMPLY(a_trip_is_error, out_valid_r && out_word_r.overheat_trip, !out_word_r.heater_on && out_word_r.heater_mode == bht_pkg::MODE_ERROR, "trip without error mode and cut drive")
  `BHT_ASSERT_IMPLY(a_floor_held, out_valid_r, out_word_r.surface_max >= bht_pkg::SURF_FLOOR, "surface maximum below floor")
  `BHT_ASSERT_IMPLY(a_no_heater_no_drive, out_valid_r && HEATER_PRESENT == 0, !out_word_r.heater_on, "drive without a heater")
  `BHT_ASSERT_NEXT(a_accept_loads, in_valid && !in_stall, s1_valid_r, "accepted word not held in input register")

endmodule

>>> rtl/core/bht_cfg_regs.sv
// Configuration register bank of the battery heater thermostat.
module bht_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bht_pkg::CFG_DAT_W-1:0]  cfg_data,
  output bht_pkg::bht_cfg_t              cfg
);

  bht_pkg::bht_cfg_t cfg_r;
  bht_pkg::bht_cfg_t cfg_nxt;
  logic signed [bht_pkg::TEMP_W-1:0] byte_val;

  assign cfg_ready = 1'b1;
  assign byte_val  = cfg_data[bht_pkg::TEMP_W-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        bht_pkg::REG_CELL_ON_WALL:  cfg_nxt.cell_on_temp_wall     = byte_val;
        bht_pkg::REG_CELL_OFF_WALL: cfg_nxt.cell_off_temp_wall    = byte_val;
        bht_pkg::REG_CELL_ON_BATT:  cfg_nxt.cell_on_temp_battery  = byte_val;
        bht_pkg::REG_CELL_OFF_BATT: cfg_nxt.cell_off_temp_battery = byte_val;
        bht_pkg::REG_SOC_MIN:       cfg_nxt.soc_min_for_heat      = cfg_data;
        bht_pkg::REG_SURF_ON:       cfg_nxt.surface_on_temp       = byte_val;
        bht_pkg::REG_SURF_OFF:      cfg_nxt.surface_off_temp      = byte_val;
        bht_pkg::REG_SURF_CRIT:     cfg_nxt.surface_critical_temp = byte_val;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_on_temp_wall     <= 8'sd0;
      cfg_r.cell_off_temp_wall    <= 8'sd5;
      cfg_r.cell_on_temp_battery  <= -8'sd5;
      cfg_r.cell_off_temp_battery <= 8'sd0;
      cfg_r.soc_min_for_heat      <= 14'd5000;
      cfg_r.surface_on_temp       <= 8'sd40;
      cfg_r.surface_off_temp      <= 8'sd50;
      cfg_r.surface_critical_temp <= 8'sd70;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/bht_surface_max.sv
// Largest heater surface reading over the fitted sensors, floored at -99.
module bht_surface_max #(
  parameter int SURFACE_SENSORS = bht_pkg::SURFACE_SENSORS_DEF
) (
  input  logic signed [bht_pkg::TEMP_W-1:0] temp_a,
  input  logic signed [bht_pkg::TEMP_W-1:0] temp_b,
  input  logic signed [bht_pkg::TEMP_W-1:0] temp_c,
  output logic signed [bht_pkg::TEMP_W-1:0] surface_max
);

  // Only the wired sensor inputs can be fitted, and at least one always is.
  localparam int NSENS = (SURFACE_SENSORS > bht_pkg::SENSOR_INPUTS) ? bht_pkg::SENSOR_INPUTS :
                         (SURFACE_SENSORS < 1) ? 1 : SURFACE_SENSORS;

  logic signed [bht_pkg::TEMP_W-1:0] temps [bht_pkg::SENSOR_INPUTS];

  assign temps[0] = temp_a;
  assign temps[1] = temp_b;
  assign temps[2] = temp_c;

  always_comb begin
    surface_max = bht_pkg::SURF_FLOOR;
    for (int i = 0; i < bht_pkg::SENSOR_INPUTS; i++) begin
      if (i < NSENS && temps[i] > surface_max) begin
        surface_max = temps[i];
      end
    end
  end

endmodule

>>> rtl/core/bht_mode_ctrl.sv
// Safety check, command handling, mode machine and drive hysteresis.
module bht_mode_ctrl #(
  parameter int HEATER_PRESENT = bht_pkg::HEATER_PRESENT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              advance,
  input  bht_pkg::bht_in_t                  word_in,
  input  logic signed [bht_pkg::TEMP_W-1:0] smax,
  input  bht_pkg::bht_cfg_t                 cfg,
  output bht_pkg::bht_out_t                 word_out
);

  localparam logic HEAT = (HEATER_PRESENT != 0);
  localparam logic [bht_pkg::MODE_W-1:0] MODE_IDLE = HEAT ? bht_pkg::MODE_OFF
                                                          : bht_pkg::MODE_DISABLED;

  logic [bht_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic                       drive_r, drive_nxt;
  logic                       manual_r, manual_nxt;
  logic                       trip;

  logic signed [bht_pkg::TEMP_W-1:0] cell_temp;
  logic [bht_pkg::SOC_W-1:0]         soc;
  logic                              wall;
  logic                              hyst_on;
  logic                              hyst_off;

  assign cell_temp = word_in.min_cell_temp;
  assign soc       = word_in.charge_level;
  assign wall      = word_in.wall_power;

  assign hyst_on  = HEAT && (smax < cfg.surface_on_temp);
  assign hyst_off = HEAT && (smax >= cfg.surface_off_temp);

  always_comb begin
    logic reinit;
    reinit     = 1'b0;
    mode_nxt   = mode_r;
    drive_nxt  = drive_r;
    manual_nxt = manual_r;
    trip       = 1'b0;

    // The command acts before the sample is evaluated.
    unique case (word_in.cmd)
      bht_pkg::CMD_AUTO: begin
        manual_nxt = 1'b0;
        mode_nxt   = bht_pkg::MODE_OFF;
      end
      bht_pkg::CMD_FORCE_ON: begin
        manual_nxt = 1'b1;
        mode_nxt   = bht_pkg::MODE_FORCED;
      end
      bht_pkg::CMD_FORCE_OFF: begin
        manual_nxt = 1'b1;
        mode_nxt   = bht_pkg::MODE_OFF;
      end
      bht_pkg::CMD_REINIT: reinit = 1'b1;
      default: ;
    endcase

    if (HEAT) begin
      if (smax >= cfg.surface_off_temp) begin
        drive_nxt = 1'b0;
      end
      if (smax > cfg.surface_critical_temp) begin
        drive_nxt = 1'b0;
        mode_nxt  = bht_pkg::MODE_ERROR;
        trip      = 1'b1;
      end
    end

    // A trip on the same sample outranks reinitialisation.
    if (reinit && !trip) begin
      mode_nxt  = MODE_IDLE;
      drive_nxt = 1'b0;
    end

    unique case (mode_nxt)
      bht_pkg::MODE_OFF: begin
        drive_nxt = 1'b0;
        if (!manual_nxt && cell_temp < cfg.cell_off_temp_wall) begin
          if (wall) begin
            if (cell_temp <= cfg.cell_on_temp_wall) begin
              mode_nxt = bht_pkg::MODE_WALL;
            end
          end else if (cell_temp <= cfg.cell_on_temp_battery &&
                       soc > cfg.soc_min_for_heat) begin
            mode_nxt = bht_pkg::MODE_BATT;
          end
        end
      end
      bht_pkg::MODE_FORCED: begin
        if (manual_nxt) begin
          if (hyst_on) drive_nxt = 1'b1;
          else if (hyst_off) drive_nxt = 1'b0;
        end else begin
          mode_nxt = bht_pkg::MODE_OFF;
        end
      end
      bht_pkg::MODE_BATT: begin
        if (!wall && cell_temp <= cfg.cell_off_temp_battery &&
            soc > cfg.soc_min_for_heat) begin
          if (hyst_on) drive_nxt = 1'b1;
          else if (hyst_off) drive_nxt = 1'b0;
        end else begin
          mode_nxt = bht_pkg::MODE_OFF;
        end
      end
      bht_pkg::MODE_WALL: begin
        if (wall && cell_temp <= cfg.cell_off_temp_wall) begin
          if (hyst_on) drive_nxt = 1'b1;
          else if (hyst_off) drive_nxt = 1'b0;
        end else begin
          mode_nxt = bht_pkg::MODE_OFF;
        end
      end
      bht_pkg::MODE_ERROR: drive_nxt = 1'b0;
      default: ;
    endcase

    // Without a heater nothing ever drives.
    if (!HEAT) begin
      drive_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      drive_r  <= 1'b0;
      manual_r <= 1'b0;
    end else if (advance) begin
      mode_r   <= mode_nxt;
      drive_r  <= drive_nxt;
      manual_r <= manual_nxt;
    end
  end

  assign word_out.heater_on     = drive_nxt;
  assign word_out.heater_mode   = mode_nxt;
  assign word_out.overheat_trip = trip;
  assign word_out.surface_max   = smax;

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the battery heater thermostat: random and directed sensor words.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bht_pkg::*;

  // Command codes the block treats as a plain tick.
  localparam logic [CMD_W-1:0] CMD_UNUSED_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int MAX_REPORTS      = 10;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  bht_in_t              in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  bht_out_t             out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // Sensor words waiting to be sent and heater status words still owed by the block.
  bht_in_t  sample_q[$];
  bht_out_t heater_status_q[$];

  // Own copy of the thresholds and of the controller state.
  bht_cfg_t thresholds = '{8'sd0, 8'sd5, -8'sd5, 8'sd0, 14'd5000, 8'sd40, 8'sd50, 8'sd70};
  logic [MODE_W-1:0] pred_mode = MODE_OFF;
  logic              pred_drive = 1'b0;
  logic              pred_manual = 1'b0;

  int   mismatch_count = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  logic idle_on = 1'b1;
  int   hold_req_cnt = 0;
  int   hold_ack_cnt = 0;
  int   hold_left = 0;

  battery_heater_thermostat i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic void surface_hysteresis(logic signed [TEMP_W-1:0] smax);
    if (smax < $signed(thresholds.surface_on_temp)) begin
      pred_drive = 1'b1;
    end else if (smax >= $signed(thresholds.surface_off_temp)) begin
      pred_drive = 1'b0;
    end
  endfunction

  // Works out the status word for one sensor word and advances the controller state.
  function automatic bht_out_t heater_predict(bht_in_t w);
    logic signed [TEMP_W-1:0] smax;
    logic signed [TEMP_W-1:0] cell_temp;
    logic                     reinit;
    logic                     trip;
    bht_out_t                 r;
    reinit    = 1'b0;
    trip      = 1'b0;
    cell_temp = $signed(w.min_cell_temp);
    case (w.cmd)
      CMD_AUTO: begin
        pred_manual = 1'b0;
        pred_mode   = MODE_OFF;
      end
      CMD_FORCE_ON: begin
        pred_manual = 1'b1;
        pred_mode   = MODE_FORCED;
      end
      CMD_FORCE_OFF: begin
        pred_manual = 1'b1;
        pred_mode   = MODE_OFF;
      end
      CMD_REINIT: reinit = 1'b1;
      default: ;
    endcase

    smax = SURF_FLOOR;
    if ($signed(w.surface_temp_a) > smax) smax = $signed(w.surface_temp_a);
    if ($signed(w.surface_temp_b) > smax) smax = $signed(w.surface_temp_b);
    if ($signed(w.surface_temp_c) > smax) smax = $signed(w.surface_temp_c);

    if (smax >= $signed(thresholds.surface_off_temp)) pred_drive = 1'b0;
    if (smax > $signed(thresholds.surface_critical_temp)) begin
      pred_drive = 1'b0;
      pred_mode  = MODE_ERROR;
      trip       = 1'b1;
    end
    // A trip on the same word overrides a reinitialise.
    if (reinit && !trip) begin
      pred_mode  = MODE_OFF;
      pred_drive = 1'b0;
    end

    case (pred_mode)
      MODE_OFF: begin
        pred_drive = 1'b0;
        if (!pred_manual && cell_temp < $signed(thresholds.cell_off_temp_wall)) begin
          if (w.wall_power) begin
            if (cell_temp <= $signed(thresholds.cell_on_temp_wall)) pred_mode = MODE_WALL;
          end else if (cell_temp <= $signed(thresholds.cell_on_temp_battery) &&
                       w.charge_level > thresholds.soc_min_for_heat) begin
            pred_mode = MODE_BATT;
          end
        end
      end
      MODE_FORCED: begin
        if (pred_manual) surface_hysteresis(smax);
        else pred_mode = MODE_OFF;
      end
      MODE_BATT: begin
        if (!w.wall_power && cell_temp <= $signed(thresholds.cell_off_temp_battery) &&
            w.charge_level > thresholds.soc_min_for_heat) begin
          surface_hysteresis(smax);
        end else begin
          pred_mode = MODE_OFF;
        end
      end
      MODE_WALL: begin
        if (w.wall_power && cell_temp <= $signed(thresholds.cell_off_temp_wall)) begin
          surface_hysteresis(smax);
        end else begin
          pred_mode = MODE_OFF;
        end
      end
      MODE_ERROR: pred_drive = 1'b0;
      default: ;
    endcase

    r.heater_on     = pred_drive;
    r.heater_mode   = pred_mode;
    r.overheat_trip = trip;
    r.surface_max   = smax;
    return r;
  endfunction

  // Mostly back to back, sometimes a short gap, now and then a long one (none if !idle_on).
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic int rand_temp();
    return int'($urandom_range(0, 255)) - 128;
  endfunction

  function automatic int clamp_temp(int v);
    if (v < -128) return -128;
    if (v > 127) return 127;
    return v;
  endfunction

  // Sender: holds a stalled word, otherwise takes the next one from the queue after its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        heater_status_q.push_back(heater_predict(in_word));
      end
      if (in_valid && in_stall) begin
        // The word stays on the bus unchanged.
      end else if (send_gap != 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        in_word  <= sample_q.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold, started on request from the stimulus.
  always @(posedge clk) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left    <= LONG_HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks each status word against the oldest prediction and stalls at random.
  always @(posedge clk) begin
    bht_out_t exp_word;
    logic     next_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (heater_status_q.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("%0t: status word with nothing owed: on=%0d mode=%0d trip=%0d smax=%0d",
                   $time, out_word.heater_on, out_word.heater_mode,
                   out_word.overheat_trip, $signed(out_word.surface_max));
        end
        mismatch_count = mismatch_count + 1;
      end else begin
        exp_word = heater_status_q.pop_front();
        if (out_word.heater_on !== exp_word.heater_on ||
            out_word.heater_mode !== exp_word.heater_mode ||
            out_word.overheat_trip !== exp_word.overheat_trip ||
            out_word.surface_max !== exp_word.surface_max) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("%0t: expected on=%0d mode=%0d trip=%0d smax=%0d, got on=%0d mode=%0d trip=%0d smax=%0d",
                     $time, exp_word.heater_on, exp_word.heater_mode,
                     exp_word.overheat_trip, $signed(exp_word.surface_max),
                     out_word.heater_on, out_word.heater_mode,
                     out_word.overheat_trip, $signed(out_word.surface_max));
          end
          mismatch_count = mismatch_count + 1;
        end
      end
    end
    if (hold_left != 0) begin
      next_stall = 1'b1;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      next_stall = 1'b1;
    end else begin
      next_stall = 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
    out_stall <= next_stall;
  end

  task automatic add_sample(logic [CMD_W-1:0] cmd, int cell_temp, int sa, int sb, int sc,
                            logic wall, int soc);
    bht_in_t s;
    s.cmd            = cmd;
    s.min_cell_temp  = cell_temp[7:0];
    s.surface_temp_a = sa[7:0];
    s.surface_temp_b = sb[7:0];
    s.surface_temp_c = sc[7:0];
    s.wall_power     = wall;
    s.charge_level   = soc[SOC_W-1:0];
    sample_q.push_back(s);
  endtask

  // Slowly drifting temperatures and charge around the thresholds in force, with
  // occasional commands and a sprinkling of fully random words.
  task automatic add_walk_samples(int count);
    int                cell_temp;
    int                surf;
    int                soc;
    int                sv[3];
    logic              wall;
    logic [CMD_W-1:0]  cmd;
    @(negedge clk);
    cell_temp = int'($signed(thresholds.cell_on_temp_battery));
    surf      = int'($signed(thresholds.surface_on_temp));
    soc       = int'(thresholds.soc_min_for_heat);
    wall      = 1'($urandom_range(0, 1));
    repeat (count) begin
      if ($urandom_range(0, 99) < 8) begin
        add_sample(3'($urandom_range(0, 7)), rand_temp(), rand_temp(), rand_temp(),
                   rand_temp(), 1'($urandom_range(0, 1)), $urandom_range(0, 16383));
      end else begin
        cmd = ($urandom_range(0, 99) < 82) ? CMD_TICK :
              3'($urandom_range(CMD_AUTO, CMD_UNUSED_7));
        if ($urandom_range(0, 19) == 0) begin
          case ($urandom_range(0, 3))
            0: cell_temp = int'($signed(thresholds.cell_on_temp_wall));
            1: cell_temp = int'($signed(thresholds.cell_off_temp_wall));
            2: cell_temp = int'($signed(thresholds.cell_on_temp_battery));
            default: cell_temp = int'($signed(thresholds.cell_off_temp_battery));
          endcase
          cell_temp = clamp_temp(cell_temp + int'($urandom_range(0, 6)) - 3);
        end else begin
          cell_temp = clamp_temp(cell_temp + int'($urandom_range(0, 4)) - 2);
        end
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 4))
            0, 1: surf = int'($signed(thresholds.surface_on_temp));
            2, 3: surf = int'($signed(thresholds.surface_off_temp));
            default: surf = int'($signed(thresholds.surface_critical_temp));
          endcase
          surf = clamp_temp(surf + int'($urandom_range(0, 6)) - 3);
        end else begin
          surf = clamp_temp(surf + int'($urandom_range(0, 6)) - 3);
        end
        if ($urandom_range(0, 29) == 0) wall = ~wall;
        if ($urandom_range(0, 9) == 0) begin
          soc = int'(thresholds.soc_min_for_heat) + int'($urandom_range(0, 10)) - 5;
        end else begin
          soc = soc + int'($urandom_range(0, 40)) - 20;
        end
        if (soc < 0) soc = 0;
        if (soc > 16383) soc = 16383;
        for (int k = 0; k < 3; k++) begin
          sv[k] = clamp_temp(surf - int'($urandom_range(0, 4)));
          // A sensor reading below the floor now and then.
          if ($urandom_range(0, 9) == 0) sv[k] = int'($urandom_range(0, 28)) - 128;
        end
        sv[$urandom_range(0, 2)] = surf;
        add_sample(cmd, cell_temp, sv[0], sv[1], sv[2], wall, soc);
      end
    end
  endtask

  // Returns at a rising edge with the register word accepted.
  task automatic write_threshold(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    // Temperature registers only use the low byte, so the upper bits are random.
    if (idx == REG_SOC_MIN) cfg_data <= value[CFG_DAT_W-1:0];
    else cfg_data <= {6'($urandom_range(0, 63)), value[7:0]};
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CELL_ON_WALL:  thresholds.cell_on_temp_wall     = value[7:0];
      REG_CELL_OFF_WALL: thresholds.cell_off_temp_wall    = value[7:0];
      REG_CELL_ON_BATT:  thresholds.cell_on_temp_battery  = value[7:0];
      REG_CELL_OFF_BATT: thresholds.cell_off_temp_battery = value[7:0];
      REG_SOC_MIN:       thresholds.soc_min_for_heat      = value[SOC_W-1:0];
      REG_SURF_ON:       thresholds.surface_on_temp       = value[7:0];
      REG_SURF_OFF:      thresholds.surface_off_temp      = value[7:0];
      default:           thresholds.surface_critical_temp = value[7:0];
    endcase
  endtask

  task automatic apply_thresholds(int cw_on, int cw_off, int cb_on, int cb_off, int soc,
                                  int s_on, int s_off, int s_crit);
    @(posedge clk);
    write_threshold(REG_CELL_ON_WALL, cw_on);
    write_threshold(REG_CELL_OFF_WALL, cw_off);
    write_threshold(REG_CELL_ON_BATT, cb_on);
    write_threshold(REG_CELL_OFF_BATT, cb_off);
    write_threshold(REG_SOC_MIN, soc);
    write_threshold(REG_SURF_ON, s_on);
    write_threshold(REG_SURF_OFF, s_off);
    write_threshold(REG_SURF_CRIT, s_crit);
    cfg_valid <= 1'b0;
  endtask

  // Blocks until every queued word has gone out and every status word has come back.
  task automatic wait_idle();
    @(negedge clk);
    while (sample_q.size() != 0 || in_valid || heater_status_q.size() != 0) @(negedge clk);
  endtask

  task automatic apply_ordered_thresholds();
    int base;
    int s_on;
    int s_off;
    base  = int'($urandom_range(0, 30)) - 25;
    s_on  = $urandom_range(10, 60);
    s_off = s_on + int'($urandom_range(1, 15));
    apply_thresholds(base, base + int'($urandom_range(1, 8)), base - int'($urandom_range(0, 8)),
                     base + int'($urandom_range(0, 4)), $urandom_range(0, 10000),
                     s_on, s_off, s_off + int'($urandom_range(0, 20)));
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset thresholds.
    @(negedge clk);
    add_sample(CMD_TICK, 20, -128, -128, -128, 1'b0, 0);
    add_sample(CMD_TICK, 20, 127, 127, 127, 1'b1, 16383);
    add_sample(CMD_TICK, -128, 0, 0, 0, 1'b0, 9000);
    add_sample(CMD_REINIT, 20, 10, 75, 10, 1'b0, 9000);
    add_sample(CMD_REINIT, 20, 20, 20, 20, 1'b0, 9000);
    add_sample(CMD_AUTO, -10, 5, 10, 20, 1'b0, 10000);
    add_sample(CMD_TICK, -10, 5, 10, 20, 1'b0, 10000);
    add_sample(CMD_TICK, -10, 45, 10, 20, 1'b0, 10000);
    add_sample(CMD_TICK, -10, 50, 10, 20, 1'b0, 10000);
    add_sample(CMD_TICK, -10, 45, 10, 20, 1'b0, 10000);
    add_sample(CMD_TICK, -10, 30, 10, 20, 1'b0, 5000);
    add_sample(CMD_TICK, 0, 30, 10, 20, 1'b1, 5000);
    add_sample(CMD_TICK, 5, 10, 30, 20, 1'b1, 0);
    add_sample(CMD_TICK, 6, 10, 30, 20, 1'b1, 0);
    add_sample(CMD_FORCE_ON, 100, 10, 10, 10, 1'b0, 0);
    add_sample(CMD_TICK, 100, 60, 10, 10, 1'b0, 0);
    add_sample(CMD_FORCE_OFF, 100, 10, 10, 10, 1'b0, 0);
    add_sample(CMD_TICK, -50, 10, 10, 10, 1'b1, 10000);
    add_sample(CMD_UNUSED_5, -50, 10, 10, 10, 1'b1, 10000);
    add_sample(CMD_UNUSED_6, -50, -100, -99, -128, 1'b0, 10000);
    add_sample(CMD_UNUSED_7, -50, 70, 70, 70, 1'b0, 10000);
    add_sample(CMD_FORCE_ON, 0, 71, 0, 0, 1'b0, 0);
    add_sample(CMD_FORCE_OFF, 0, 0, 0, 0, 1'b0, 0);
    add_sample(CMD_AUTO, -128, 0, 0, 0, 1'b0, 16383);
    add_sample(CMD_REINIT, -128, 30, 20, -10, 1'b0, 16383);
    add_walk_samples(90);
    wait_idle();

    // Fully random thresholds.
    apply_thresholds(rand_temp(), rand_temp(), rand_temp(), rand_temp(),
                     $urandom_range(0, 16383), rand_temp(), rand_temp(), rand_temp());
    add_walk_samples(70);
    wait_idle();

    // Lowest thresholds: every word trips.
    apply_thresholds(-128, -128, -128, -128, 16383, -128, -128, -128);
    add_walk_samples(40);
    wait_idle();

    // Highest thresholds, back to back on both sides.
    idle_on = 1'b0;
    apply_thresholds(127, 127, 127, 127, 0, 127, 127, 127);
    add_walk_samples(60);
    wait_idle();
    idle_on = 1'b1;

    // Ordered thresholds with the receiver held off long enough to back up the input.
    apply_ordered_thresholds();
    add_walk_samples(100);
    hold_req_cnt = hold_req_cnt + 1;
    wait_idle();

    apply_ordered_thresholds();
    add_walk_samples(70);
    wait_idle();

    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && heater_status_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
